// ===== src/sorted_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTH
// property checked at every edge outside reset
`define SPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sorted_priority_queue assertion failed");
// property checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sorted_priority_queue assertion failed");
`else
`define SPQ_ASSERT(label, clk, rst_n, prop)
`define SPQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// types and codes shared by the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEFAULT = 8;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_PEEK   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] payload;
        logic [7:0] prio;
    } t_req_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] front_payload;
        logic [7:0] front_prio;
    } t_rsp_item;

    typedef struct packed {
        logic [7:0] prio;
        logic [7:0] payload;
    } t_entry;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic       insert;
        logic       pop;
        logic [7:0] prio;
        logic [7:0] payload;
    } t_cell_ctl;

endpackage

// ===== src/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_if
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic               valid;
    logic               ready;
    spq_pkg::t_req_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
    logic               valid;
    logic               ready;
    spq_pkg::t_rsp_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one queue slot: keeps, takes the new entry, or takes a neighbor's entry
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_live,
    input  logic               i_prev_le,
    input  spq_pkg::t_entry    i_prev,
    input  spq_pkg::t_entry    i_next,
    output spq_pkg::t_entry    o_entry,
    output logic               o_le
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            w_le;

    // live entry that stays ahead of the new one
    assign w_le = i_live && (r_entry.prio <= i_ctl.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert) begin
            if (w_le) begin
                n_entry = r_entry;
            end else if (i_prev_le) begin
                n_entry.prio    = i_ctl.prio;
                n_entry.payload = i_ctl.payload;
            end else begin
                n_entry = i_prev;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_le    = w_le;

endmodule

// ===== src/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue held as a row of sorted cells
// ----------------------------------------------------------------------------
// requests arrive on i_req (insert, pop, peek) and every request gives
// exactly one response on o_rsp with a status and, for pop or peek, the
// front entry. cells hold entries in ascending priority; on insert every
// cell compares its priority with the new one at once and either keeps,
// takes the new entry or takes its left neighbor's; on pop every cell
// takes its right neighbor's entry. equal priorities leave in arrival order.
// the response is registered and valid in the cycle after the request
// transfer. throughput: one request per cycle while the receiver takes
// responses, set by the single compare-and-shift step of the cell row.
// reset clears the live count and the response valid flag; cell contents
// are not cleared and only live cells are ever read.
// when the receiver stalls, the response is held and a new request is
// taken only in the cycle that the held response leaves.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_rsp_valid;
    logic               n_rsp_valid;
    spq_pkg::t_rsp_item r_rsp;
    spq_pkg::t_rsp_item n_rsp;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_is_insert;
    logic               w_is_pop;
    logic               w_is_peek;
    spq_pkg::t_cell_ctl w_ctl;

    logic            [DEPTH-1:0] w_live;
    logic            [DEPTH-1:0] w_le;
    spq_pkg::t_entry [DEPTH-1:0] w_entry;

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_is_insert = (i_req.data.req_type == spq_pkg::REQ_INSERT);
    assign w_is_pop    = (i_req.data.req_type == spq_pkg::REQ_POP);
    assign w_is_peek   = (i_req.data.req_type == spq_pkg::REQ_PEEK);

    always_comb begin
        w_ctl.insert  = w_accept && w_is_insert && !w_full;
        w_ctl.pop     = w_accept && w_is_pop && !w_empty;
        w_ctl.prio    = i_req.data.prio;
        w_ctl.payload = i_req.data.payload;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign w_live[gi] = (r_count > CW'(gi));

            if (gi == 0) begin : g_first
                spq_cell u_cell (
                    .i_clk     (i_clk),
                    .i_ctl     (w_ctl),
                    .i_live    (w_live[gi]),
                    .i_prev_le (1'b1),
                    .i_prev    (w_entry[gi]),
                    .i_next    (w_entry[gi+1]),
                    .o_entry   (w_entry[gi]),
                    .o_le      (w_le[gi])
                );
            end else if (gi == DEPTH - 1) begin : g_last
                spq_cell u_cell (
                    .i_clk     (i_clk),
                    .i_ctl     (w_ctl),
                    .i_live    (w_live[gi]),
                    .i_prev_le (w_le[gi-1]),
                    .i_prev    (w_entry[gi-1]),
                    .i_next    (w_entry[gi]),
                    .o_entry   (w_entry[gi]),
                    .o_le      (w_le[gi])
                );
            end else begin : g_mid
                spq_cell u_cell (
                    .i_clk     (i_clk),
                    .i_ctl     (w_ctl),
                    .i_live    (w_live[gi]),
                    .i_prev_le (w_le[gi-1]),
                    .i_prev    (w_entry[gi-1]),
                    .i_next    (w_entry[gi+1]),
                    .o_entry   (w_entry[gi]),
                    .o_le      (w_le[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctl.insert) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        if (w_accept) begin
            n_rsp_valid         = 1'b1;
            n_rsp.status        = spq_pkg::ST_OK;
            n_rsp.front_payload = '0;
            n_rsp.front_prio    = '0;
            if (w_is_insert) begin
                if (w_full) begin
                    n_rsp.status = spq_pkg::ST_FULL;
                end
            end else if (w_is_pop || w_is_peek) begin
                if (w_empty) begin
                    n_rsp.status = spq_pkg::ST_EMPTY;
                end else begin
                    n_rsp.front_payload = w_entry[0].payload;
                    n_rsp.front_prio    = w_entry[0].prio;
                end
            end
        end else if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    // live count stays within the row of cells
    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    // rejected insert leaves the count alone
    `SPQ_ASSERT(a_full_hold, i_clk, i_rst_n, (w_accept && w_is_insert && w_full) |=> (r_count == $past(r_count)))
    // pop from a non-empty queue frees exactly one cell
    `SPQ_ASSERT(a_pop_count, i_clk, i_rst_n, (w_accept && w_is_pop && !w_empty) |=> (r_count == $past(r_count) - CW'(1)))
    // front two cells stay in priority order
    `SPQ_ASSERT(a_sorted_front, i_clk, i_rst_n, (r_count >= CW'(2)) |-> (w_entry[0].prio <= w_entry[1].prio))
    // pop or peek on an empty queue reports empty
    `SPQ_ASSERT(a_empty_status, i_clk, i_rst_n, (w_accept && (w_is_pop || w_is_peek) && w_empty) |=> (o_rsp.data.status == spq_pkg::ST_EMPTY))

endmodule

// ===== verif/sorted_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// self-checking bench for the sorted priority queue: a directed pass over
// empty, full, tie and unused-code cases, then random fill/drain traffic
// with random sender gaps and receiver stalls, checked against a
// cycle-free model of the sorted slot array
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1826;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 8;

    // request code the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [1:0] {GEN_FILL, GEN_DRAIN, GEN_MIXED} t_gen_mode;
    typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_MOSTLY, RX_BURSTY} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spq_req_if req_if();
    spq_rsp_if rsp_if();

    sorted_priority_queue #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    t_req_item pending_req_q[$];
    t_rsp_item expected_rsp_q[$];

    // model of the queue contents
    t_entry model_slot[DEPTH];
    int     model_count = 0;

    int gen_count = 0;
    int fail_count = 0;
    int idle_cycles = 0;
    bit run_done = 1'b0;
    int gap_left = 0;
    int burst_left = 16;
    int stall_left = 0;
    int rx_cyc = 0;
    int n_insert = 0, n_full = 0, n_pop = 0, n_peek = 0, n_empty = 0, n_unused = 0;

    function automatic t_rsp_item predict_queue_response(t_req_item r);
        t_rsp_item rsp;
        int pos;
        rsp = '0;
        rsp.status = ST_OK;
        case (r.req_type)
            REQ_INSERT: begin
                if (model_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    // new entry goes behind every entry of lower or equal priority
                    pos = 0;
                    while (pos < model_count && model_slot[pos].prio <= r.prio)
                        pos++;
                    for (int i = model_count; i > pos; i--)
                        model_slot[i] = model_slot[i-1];
                    model_slot[pos].prio    = r.prio;
                    model_slot[pos].payload = r.payload;
                    model_count++;
                end
            end
            REQ_POP, REQ_PEEK: begin
                if (model_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.front_payload = model_slot[0].payload;
                    rsp.front_prio    = model_slot[0].prio;
                    if (r.req_type == REQ_POP) begin
                        for (int i = 1; i < model_count; i++)
                            model_slot[i-1] = model_slot[i];
                        model_count--;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic queue_request(logic [1:0] kind, logic [7:0] pay, logic [7:0] pri);
        t_req_item r;
        r.req_type = kind;
        r.payload  = pay;
        r.prio     = pri;
        pending_req_q.push_back(r);
        if (kind == REQ_INSERT && gen_count < DEPTH)
            gen_count++;
        else if (kind == REQ_POP && gen_count > 0)
            gen_count--;
    endtask

    // driver: holds an item until transfer, bursts separated by gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (pending_req_q.size() > 0) begin
                req_if.data  <= pending_req_q.pop_front();
                req_if.valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, mode stepped by a free-running cycle counter
    always @(posedge i_clk) begin
        rx_cyc++;
        case (t_rx_mode'(rx_cyc[8:7]))
            RX_STEADY: rsp_if.ready <= 1'b1;
            RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: rsp_if.ready <= ($urandom_range(0, 4) != 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    rsp_if.ready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_left = $urandom_range(2, 12);
                    rsp_if.ready <= 1'b0;
                end else begin
                    rsp_if.ready <= 1'b1;
                end
            end
        endcase
    end

    // monitor: check responses first, then predict for the request transfer
    always @(posedge i_clk) begin : monitor
        t_rsp_item want;
        t_rsp_item got;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: response with none pending: status %0d payload %0h prio %0h",
                             $time, got.status, got.front_payload, got.front_prio);
                    fail_count++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        fail_count++;
                    end
                    if (got.front_payload !== want.front_payload) begin
                        $display("%0t: front_payload expected %0h actual %0h",
                                 $time, want.front_payload, got.front_payload);
                        fail_count++;
                    end
                    if (got.front_prio !== want.front_prio) begin
                        $display("%0t: front_prio expected %0h actual %0h",
                                 $time, want.front_prio, got.front_prio);
                        fail_count++;
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                want = predict_queue_response(req_if.data);
                expected_rsp_q.push_back(want);
                case (req_if.data.req_type)
                    REQ_INSERT: if (want.status == ST_FULL) n_full++; else n_insert++;
                    REQ_POP:    n_pop++;
                    REQ_PEEK:   n_peek++;
                    default:    n_unused++;
                endcase
                if (want.status == ST_EMPTY)
                    n_empty++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n && !run_done) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("sorted_priority_queue_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_gen_mode mode;
        int roll;
        int sel;
        logic [1:0] kind;
        logic [7:0] pri;
        logic [1:0] ext;

        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;

        // empty queue and the unused code
        queue_request(REQ_PEEK, 8'h5A, 8'h00);
        queue_request(REQ_POP, 8'hA5, 8'hFF);
        queue_request(REQ_UNUSED, 8'hFF, 8'hFF);
        // extremes, ties at middle, front and back, then fill up
        queue_request(REQ_INSERT, 8'h00, 8'hFF);
        queue_request(REQ_INSERT, 8'hFF, 8'h00);
        queue_request(REQ_INSERT, 8'h01, 8'h80);
        queue_request(REQ_INSERT, 8'h02, 8'h80);
        queue_request(REQ_INSERT, 8'h03, 8'h80);
        queue_request(REQ_INSERT, 8'h7E, 8'h00);
        queue_request(REQ_INSERT, 8'hAA, 8'hFF);
        queue_request(REQ_INSERT, 8'h55, 8'h55);
        queue_request(REQ_INSERT, 8'hC3, 8'h01);
        queue_request(REQ_PEEK, 8'h00, 8'h00);
        queue_request(REQ_UNUSED, 8'h00, 8'h00);
        for (int i = 0; i < DEPTH; i++)
            queue_request(REQ_POP, 8'h00, 8'h00);
        queue_request(REQ_POP, 8'h00, 8'h00);
        queue_request(REQ_PEEK, 8'hFF, 8'hFF);

        mode = GEN_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            case (mode)
                GEN_FILL:  kind = (roll < 75) ? REQ_INSERT : (roll < 88) ? REQ_POP :
                                  (roll < 98) ? REQ_PEEK : REQ_UNUSED;
                GEN_DRAIN: kind = (roll < 15) ? REQ_INSERT : (roll < 80) ? REQ_POP :
                                  (roll < 98) ? REQ_PEEK : REQ_UNUSED;
                default:   kind = (roll < 45) ? REQ_INSERT : (roll < 83) ? REQ_POP :
                                  (roll < 98) ? REQ_PEEK : REQ_UNUSED;
            endcase
            // mostly narrow priorities so ties are common
            sel = $urandom_range(0, 9);
            ext = 2'($urandom_range(0, 3));
            if (sel < 5)
                pri = 8'($urandom_range(0, 7));
            else if (sel < 8)
                pri = 8'($urandom_range(0, 255));
            else
                pri = (ext[1] ? 8'd254 : 8'd0) + ext[0];
            queue_request(kind, 8'($urandom_range(0, 255)), pri);

            if (mode == GEN_FILL && gen_count == DEPTH && $urandom_range(0, 2) == 0)
                mode = GEN_DRAIN;
            else if (mode == GEN_DRAIN && gen_count == 0 && $urandom_range(0, 2) == 0)
                mode = $urandom_range(0, 1) ? GEN_FILL : GEN_MIXED;
            else if ($urandom_range(0, 59) == 0)
                mode = t_gen_mode'($urandom_range(0, 2));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_req_q.size() != 0 || req_if.valid)
            @(posedge i_clk);
        while (expected_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        run_done = 1'b1;

        $display("requests: %0d inserts, %0d refused as full, %0d pops, %0d peeks, %0d unused code",
                 n_insert, n_full, n_pop, n_peek, n_unused);
        $display("pops and peeks on an empty queue: %0d, mismatches: %0d", n_empty, fail_count);
        if (fail_count == 0)
            $display("sorted_priority_queue_tb: PASS");
        else
            $display("sorted_priority_queue_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/spq_pkg.sv
src/spq_if.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
verif/sorted_priority_queue_tb.sv
